FILE: src/framed_message_checker_crc32_defines.svh
// Assertion macros for the port checker (fmc_chk).
`ifndef FRAMED_MESSAGE_CHECKER_CRC32_DEFINES_SVH
`define FRAMED_MESSAGE_CHECKER_CRC32_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FMC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fmc check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FMC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fmc check failed");

`endif

FILE: src/fmc_pkg.sv
// Package: frame layout constants, result kinds and the byte-wide CRC-32 update.
package fmc_pkg;

	localparam int POS_W     = 17;
	localparam int SEQ_W     = 32;
	localparam int CODE_W    = 16;
	localparam int CRC_W     = 32;

	localparam logic [POS_W-1:0] POS_SEQ_FIRST = POS_W'(4);
	localparam logic [POS_W-1:0] POS_SEQ_LAST  = POS_W'(7);
	localparam logic [POS_W-1:0] POS_LEN_HI    = POS_W'(14);
	localparam logic [POS_W-1:0] POS_LEN_LO    = POS_W'(15);
	localparam logic [POS_W-1:0] POS_RC_HI     = POS_W'(18);
	localparam logic [POS_W-1:0] POS_RC_LO     = POS_W'(19);
	localparam logic [POS_W-1:0] POS_PAYLOAD   = POS_W'(20);

	localparam int HDR_BYTES = 16;
	localparam int TRL_BYTES = 8;
	localparam int SFX_BYTES = 4;
	localparam int MIN_FRAME = 28;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		KIND_PAYLOAD = 3'd0,
		KIND_OK      = 3'd1,
		KIND_CRC_ERR = 3'd2,
		KIND_DEV_ERR = 3'd3,
		KIND_LEN_ERR = 3'd4,
		KIND_TRUNC   = 3'd5
	} kind_t;

	// Reflected CRC-32, one byte, eight shift steps.
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
			input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: src/fmc_in_if.sv
// Input channel: one raw buffer byte per item.
interface fmc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source(output valid, output data_byte, output end_of_buffer, input ready);
	modport sink(input valid, input data_byte, input end_of_buffer, output ready);
endinterface

FILE: src/fmc_out_if.sv
// Output channel: payload byte or end-of-frame status per item.
interface fmc_out_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    out_kind;
	logic [7:0]                    out_byte;
	logic [fmc_pkg::SEQ_W-1:0]     seq_number;
	logic [fmc_pkg::CODE_W-1:0]    return_code;
	logic [fmc_pkg::POS_W-1:0]     frame_bytes;

	modport source(output valid, output out_kind, output out_byte, output seq_number,
		output return_code, output frame_bytes, input ready);
	modport sink(input valid, input out_kind, input out_byte, input seq_number,
		input return_code, input frame_bytes, output ready);
endinterface

FILE: src/framed_message_checker_crc32.sv
// Top level: CRC-32 checked frame deframer for a byte stream of back-to-back frames.
//
//   channel     dir   handshake      payload
//   frame_data  in    valid/ready    data_byte[7:0], end_of_buffer
//   result      out   valid/ready    out_kind[2:0], out_byte[7:0], seq_number[31:0],
//                                    return_code[15:0], frame_bytes[16:0]
//
// One byte per cycle sustained while the sink takes results. An item is
// registered in the input stage (_s1) and is then judged in one pass (header
// capture, one-byte CRC step, end-of-frame compare) into the result register.
// arst_n clears the frame state to the start of a new frame, CRC preset to
// all ones, and empties both stages.
// The input stage moves on whenever the result register is empty or being
// taken, so frame_data.ready drops only while result is held by the sink.
module framed_message_checker_crc32 (
	input  logic       clk,
	input  logic       arst_n,
	fmc_in_if.sink     frame_data,
	fmc_out_if.source  result
);

	localparam int PW = fmc_pkg::POS_W;
	localparam int CW = fmc_pkg::CRC_W;
	localparam int SW = fmc_pkg::SEQ_W;
	localparam int DW = fmc_pkg::CODE_W;

	// input stage
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        eob_s1;

	// frame state
	logic [PW-1:0] pos_q;
	logic [PW-1:0] len_q;
	logic [DW-1:0] code_q;
	logic [CW-1:0] crc_q;
	logic [CW-1:0] rcrc_q;
	logic [SW-1:0] seq_q;
	logic          discard_q;

	// result register
	logic           out_v_q;
	fmc_pkg::kind_t kind_q;
	logic [7:0]     obyte_q;
	logic [SW-1:0]  oseq_q;
	logic [DW-1:0]  orc_q;
	logic [PW-1:0]  ofb_q;

	logic in_acc;
	logic advance;
	logic step;

	// next state and result of the item in s1
	logic [PW-1:0]  pos_n;
	logic [PW-1:0]  len_n;
	logic [DW-1:0]  code_n;
	logic [CW-1:0]  crc_n;
	logic [CW-1:0]  rcrc_n;
	logic [SW-1:0]  seq_n;
	logic           discard_n;
	logic           emit;
	fmc_pkg::kind_t kind_n;
	logic [7:0]     obyte_n;
	logic [SW-1:0]  oseq_n;
	logic [DW-1:0]  orc_n;
	logic [PW-1:0]  ofb_n;

	// one bit wider so position + trailer never wraps
	logic [PW:0] p_x;
	logic [PW:0] len_x;
	logic        in_crc;
	logic        in_rcrc;
	logic        len_err;
	logic        frame_end;
	logic        new_frame;

	assign advance          = !out_v_q || result.ready;
	assign step             = v_s1 && advance;
	assign frame_data.ready = !v_s1 || advance;
	assign in_acc           = frame_data.valid && frame_data.ready;

	always_comb begin
		pos_n     = pos_q;
		len_n     = len_q;
		code_n    = code_q;
		crc_n     = crc_q;
		rcrc_n    = rcrc_q;
		seq_n     = seq_q;
		discard_n = discard_q;
		emit      = 1'b0;
		kind_n    = fmc_pkg::KIND_PAYLOAD;
		obyte_n   = 8'd0;
		ofb_n     = '0;
		new_frame = 1'b0;
		p_x       = {1'b0, pos_q};
		len_x     = '0;
		in_crc    = 1'b0;
		in_rcrc   = 1'b0;
		len_err   = 1'b0;
		frame_end = 1'b0;

		if (discard_q) begin
			// short frame: drop everything through end of buffer
			if (eob_s1) begin
				new_frame = 1'b1;
				discard_n = 1'b0;
			end
		end else begin
			if (pos_q >= fmc_pkg::POS_SEQ_FIRST && pos_q <= fmc_pkg::POS_SEQ_LAST) begin
				seq_n = {seq_q[SW-9:0], byte_s1};
			end else if (pos_q == fmc_pkg::POS_LEN_HI) begin
				len_n = {1'b0, byte_s1, 8'd0};
			end else if (pos_q == fmc_pkg::POS_LEN_LO) begin
				len_n = (len_q | {9'd0, byte_s1}) + PW'(fmc_pkg::HDR_BYTES);
			end else if (pos_q == fmc_pkg::POS_RC_HI || pos_q == fmc_pkg::POS_RC_LO) begin
				code_n = {code_q[DW-9:0], byte_s1};
			end

			len_x   = {1'b0, len_n};
			in_crc  = (p_x < (PW+1)'(fmc_pkg::HDR_BYTES)) ||
				(p_x + (PW+1)'(fmc_pkg::TRL_BYTES) < len_x);
			in_rcrc = p_x + (PW+1)'(fmc_pkg::SFX_BYTES) < len_x;

			if (in_crc) begin
				crc_n = fmc_pkg::crc_byte(crc_q, byte_s1);
			end else if (in_rcrc) begin
				rcrc_n = {rcrc_q[CW-9:0], byte_s1};
			end

			len_err   = (pos_q == fmc_pkg::POS_LEN_LO) &&
				(len_n < PW'(fmc_pkg::MIN_FRAME));
			frame_end = (p_x >= (PW+1)'(fmc_pkg::HDR_BYTES)) &&
				(p_x + (PW+1)'(1) == len_x);

			if (len_err) begin
				emit      = 1'b1;
				kind_n    = fmc_pkg::KIND_LEN_ERR;
				ofb_n     = len_n;
				new_frame = 1'b1;
				discard_n = !eob_s1;
			end else if (frame_end) begin
				// CRC and received CRC are both settled before the last byte
				emit      = 1'b1;
				ofb_n     = len_n;
				new_frame = 1'b1;
				if (code_n != '0) begin
					kind_n = fmc_pkg::KIND_DEV_ERR;
				end else if ((crc_q ^ fmc_pkg::CRC_ONES) == rcrc_q) begin
					kind_n = fmc_pkg::KIND_OK;
				end else begin
					kind_n = fmc_pkg::KIND_CRC_ERR;
				end
			end else if (eob_s1) begin
				emit      = 1'b1;
				kind_n    = fmc_pkg::KIND_TRUNC;
				ofb_n     = (pos_q >= fmc_pkg::POS_LEN_LO) ? len_n : '0;
				new_frame = 1'b1;
			end else begin
				pos_n = pos_q + PW'(1);
				if (pos_q >= fmc_pkg::POS_PAYLOAD &&
						(p_x + (PW+1)'(fmc_pkg::TRL_BYTES) < len_x) && code_n == '0) begin
					emit    = 1'b1;
					obyte_n = byte_s1;
				end
			end
		end

		// header fields as they stand after this byte
		oseq_n = seq_n;
		orc_n  = code_n;

		if (new_frame) begin
			pos_n  = '0;
			len_n  = '0;
			code_n = '0;
			crc_n  = fmc_pkg::CRC_ONES;
			rcrc_n = '0;
			seq_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= frame_data.data_byte;
			eob_s1  <= frame_data.end_of_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			len_q     <= '0;
			code_q    <= '0;
			crc_q     <= fmc_pkg::CRC_ONES;
			rcrc_q    <= '0;
			seq_q     <= '0;
			discard_q <= 1'b0;
		end else if (step) begin
			pos_q     <= pos_n;
			len_q     <= len_n;
			code_q    <= code_n;
			crc_q     <= crc_n;
			rcrc_q    <= rcrc_n;
			seq_q     <= seq_n;
			discard_q <= discard_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			kind_q  <= kind_n;
			obyte_q <= obyte_n;
			oseq_q  <= oseq_n;
			orc_q   <= orc_n;
			ofb_q   <= ofb_n;
		end
	end

	assign result.valid       = out_v_q;
	assign result.out_kind    = kind_q;
	assign result.out_byte    = obyte_q;
	assign result.seq_number  = oseq_q;
	assign result.return_code = orc_q;
	assign result.frame_bytes = ofb_q;

endmodule

FILE: src/fmc_chk.sv
// Port checker for the frame deframer, bound to the top level.
`include "framed_message_checker_crc32_defines.svh"

module fmc_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [2:0]                 out_kind,
	input logic [7:0]                 out_byte,
	input logic [fmc_pkg::SEQ_W-1:0]  seq_number,
	input logic [fmc_pkg::CODE_W-1:0] return_code,
	input logic [fmc_pkg::POS_W-1:0]  frame_bytes
);

	// a held result keeps its payload
	`FMC_ASSERT_NEXT(a_hold, out_valid && !out_ready,
		out_valid && $stable(out_kind) && $stable(out_byte) && $stable(seq_number) &&
		$stable(return_code) && $stable(frame_bytes))

	// input backs up only behind a blocked result
	`FMC_ASSERT_NOW(a_bp, !in_ready, out_valid && !out_ready)

	// a fresh result comes from an item taken in, registered in the input stage and then in the result register
	`FMC_ASSERT_NOW(a_lat, $rose(out_valid), $past(in_valid && in_ready, 2))

	// status results carry no byte; payload results carry no length
	`FMC_ASSERT_NOW(a_fields, out_valid,
		(out_kind == fmc_pkg::KIND_PAYLOAD) ? (frame_bytes == '0) : (out_byte == 8'd0))

endmodule

bind framed_message_checker_crc32 fmc_chk u_fmc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (frame_data.valid),
	.in_ready    (frame_data.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_kind    (result.out_kind),
	.out_byte    (result.out_byte),
	.seq_number  (result.seq_number),
	.return_code (result.return_code),
	.frame_bytes (result.frame_bytes)
);

FILE: dv/framed_message_checker_crc32_tb.sv
// Testbench for the CRC-32 checked frame deframer: frame stimulus, in-bench predictor, scoreboard.
`timescale 1ns / 100ps

module framed_message_checker_crc32_tb;

	// Longest legal quiet stretch is the long sink hold-off (LONG_STALL) plus a few idle
	// bursts; anything several times past that means the block has hung.
	localparam int QUIET_LIMIT   = 3000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int REPORT_MAX    = 10;
	localparam int LONG_STALL    = 300;
	localparam int RANDOM_BYTES  = 300;
	localparam int STREAM_BYTES  = 250;

	typedef logic [7:0] byte_q_t[$];

	// One result item as the block should present it.
	typedef struct packed {
		fmc_pkg::kind_t             kind;
		logic [7:0]                 data;
		logic [fmc_pkg::SEQ_W-1:0]  seq;
		logic [fmc_pkg::CODE_W-1:0] code;
		logic [fmc_pkg::POS_W-1:0]  flen;
	} deframe_result_t;

	logic clk;
	logic arst_n;

	fmc_in_if  in_ch();
	fmc_out_if out_ch();

	framed_message_checker_crc32 u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_data (in_ch),
		.result     (out_ch)
	);

	// ---------------------------------------------------------------
	// Predictor state: a private copy of the deframer's frame context.
	// ---------------------------------------------------------------
	logic [fmc_pkg::POS_W-1:0]  rx_pos;
	logic [fmc_pkg::POS_W-1:0]  frame_len;
	logic [fmc_pkg::CODE_W-1:0] dev_code;
	logic [fmc_pkg::CRC_W-1:0]  crc_acc;
	logic [fmc_pkg::CRC_W-1:0]  rx_crc;
	logic [fmc_pkg::SEQ_W-1:0]  seq_acc;
	bit                         skip_to_eob;

	// Results still owed by the block, oldest first.
	deframe_result_t pending_results[$];

	int bytes_sent;
	int mismatch_count;
	bit src_idle_en;
	bit sink_idle_en;
	int long_stall_cycles;

	// Reflected CRC-32, one data bit at a time, LSB first.
	function automatic logic [fmc_pkg::CRC_W-1:0] crc32_step(
			input logic [fmc_pkg::CRC_W-1:0] acc, input logic [7:0] d);
		logic [fmc_pkg::CRC_W-1:0] r;
		logic                      fb;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ d[k];
			r = {1'b0, r[fmc_pkg::CRC_W-1:1]} ^ (fb ? fmc_pkg::CRC_POLY : '0);
		end
		return r;
	endfunction

	function automatic void start_frame();
		rx_pos    = '0;
		frame_len = '0;
		dev_code  = '0;
		crc_acc   = fmc_pkg::CRC_ONES;
		rx_crc    = '0;
		seq_acc   = '0;
	endfunction

	// Advance the frame context by one accepted byte; returns 1 when the byte
	// produces a result item, which is written to r.
	function automatic bit deframe_predict(input logic [7:0] b, input bit eob,
			output deframe_result_t r);
		int p;
		p = int'(rx_pos);
		r = '0;

		// After a length error everything is dropped up to the buffer end.
		if (skip_to_eob) begin
			if (eob) begin
				start_frame();
				skip_to_eob = 1'b0;
			end
			return 1'b0;
		end

		// Header field capture, all big-endian.
		if (p >= 4 && p <= 7)
			seq_acc = {seq_acc[fmc_pkg::SEQ_W-9:0], b};
		else if (p == 14)
			frame_len = {1'b0, b, 8'h00};
		else if (p == 15)
			frame_len = {1'b0, frame_len[15:8], b} + fmc_pkg::POS_W'(fmc_pkg::HDR_BYTES);
		else if (p == 18 || p == 19)
			dev_code = {dev_code[7:0], b};

		// Checksum covers everything ahead of the trailer; the first four
		// trailer bytes hold the received value, the suffix is ignored.
		if (p < fmc_pkg::HDR_BYTES || p + fmc_pkg::TRL_BYTES < int'(frame_len))
			crc_acc = crc32_step(crc_acc, b);
		else if (p + fmc_pkg::SFX_BYTES < int'(frame_len))
			rx_crc = {rx_crc[fmc_pkg::CRC_W-9:0], b};

		// Declared length too short to hold return code and trailer.
		if (p == 15 && int'(frame_len) < fmc_pkg::MIN_FRAME) begin
			r = '{kind: fmc_pkg::KIND_LEN_ERR, data: 8'h00, seq: seq_acc, code: dev_code,
				flen: frame_len};
			start_frame();
			skip_to_eob = !eob;
			return 1'b1;
		end

		// Last byte of the frame: judge it.
		if (p >= fmc_pkg::HDR_BYTES && p + 1 == int'(frame_len)) begin
			r = '{kind: fmc_pkg::KIND_OK, data: 8'h00, seq: seq_acc, code: dev_code,
				flen: frame_len};
			if (dev_code != '0)
				r.kind = fmc_pkg::KIND_DEV_ERR;
			else if (~crc_acc != rx_crc)
				r.kind = fmc_pkg::KIND_CRC_ERR;
			start_frame();
			return 1'b1;
		end

		// Buffer ran out inside the frame; length is only known from byte 15.
		if (eob) begin
			r = '{kind: fmc_pkg::KIND_TRUNC, data: 8'h00, seq: seq_acc, code: dev_code,
				flen: (p >= 15) ? frame_len : '0};
			start_frame();
			return 1'b1;
		end

		rx_pos = rx_pos + fmc_pkg::POS_W'(1);

		// Payload goes out only while the device reported success.
		if (p >= 20 && p + fmc_pkg::TRL_BYTES < int'(frame_len) && dev_code == '0) begin
			r = '{kind: fmc_pkg::KIND_PAYLOAD, data: b, seq: seq_acc, code: dev_code,
				flen: '0};
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------
	// Frame construction
	// ---------------------------------------------------------------

	// Full frame of body_len + 16 bytes (body_len >= 12). fill < 0 gives random
	// filler, else every free byte takes the fill value.
	function automatic void build_frame(input logic [31:0] seq, input int body_len,
			input logic [15:0] code, input bit bad_crc, input int fill,
			output byte_q_t q);
		int          total;
		logic [31:0] sum;
		total = body_len + fmc_pkg::HDR_BYTES;
		q = {};
		for (int i = 0; i < total; i++)
			q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
		q[4]  = seq[31:24];
		q[5]  = seq[23:16];
		q[6]  = seq[15:8];
		q[7]  = seq[7:0];
		q[14] = 8'(body_len >> 8);
		q[15] = 8'(body_len);
		q[18] = code[15:8];
		q[19] = code[7:0];
		sum = fmc_pkg::CRC_ONES;
		for (int i = 0; i < total - fmc_pkg::TRL_BYTES; i++)
			sum = crc32_step(sum, q[i]);
		sum = ~sum;
		// single flipped bit is enough for a checksum mismatch
		if (bad_crc)
			sum = sum ^ (32'h1 << $urandom_range(0, 31));
		q[total-8] = sum[31:24];
		q[total-7] = sum[23:16];
		q[total-6] = sum[15:8];
		q[total-5] = sum[7:0];
	endfunction

	// ---------------------------------------------------------------
	// Source side
	// ---------------------------------------------------------------

	// Offer one byte; entered and left at a falling edge. valid stays high on
	// return so a following byte goes out back to back.
	task automatic send_byte(input logic [7:0] b, input bit eob);
		deframe_result_t r;
		if (src_idle_en && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.data_byte     <= b;
		in_ch.end_of_buffer <= eob;
		do @(posedge clk); while (!in_ch.ready);
		if (deframe_predict(b, eob, r))
			pending_results.push_back(r);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_buffer(input byte_q_t q, input bit eob_last);
		foreach (q[i])
			send_byte(q[i], eob_last && i == q.size() - 1);
	endtask

	// Send bytes 0..cut of a frame with end_of_buffer on the last one.
	task automatic send_cut(input byte_q_t q, input int cut);
		q = q[0:cut];
		send_buffer(q, 1'b1);
	endtask

	// Header only, given length field, then extra random bytes; ends the buffer.
	task automatic send_bare_header(input logic [15:0] body, input int extra);
		byte_q_t q;
		for (int i = 0; i < fmc_pkg::HDR_BYTES + extra; i++)
			q.push_back(8'($urandom));
		q[14] = body[15:8];
		q[15] = body[7:0];
		send_buffer(q, 1'b1);
	endtask

	// Drop valid and wait until the block has delivered everything owed.
	task automatic hold_source_until_drained();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	// Mostly well-formed frames with random content; the rest cut short,
	// too short, or a header with an arbitrary length field.
	task automatic send_random_frame();
		byte_q_t q;
		int      pick;
		int      body;
		pick = $urandom_range(0, 99);
		body = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 300) : $urandom_range(12, 40);
		build_frame(32'($urandom), body,
			($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'h0,
			$urandom_range(0, 6) == 0, -1, q);
		if (pick < 8)
			send_cut(q, $urandom_range(0, q.size() - 2));
		else if (pick < 14)
			send_bare_header(16'($urandom_range(0, 11)), $urandom_range(0, 8));
		else if (pick < 18)
			send_bare_header(16'($urandom), $urandom_range(0, 24));
		else
			send_buffer(q, $urandom_range(0, 2) == 0);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	task automatic test_directed_frames();
		byte_q_t q;
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		// smallest legal frame, no payload, closes the buffer
		build_frame(32'h0, 12, 16'h0, 1'b0, -1, q);
		send_buffer(q, 1'b1);
		// all-ones filler and top sequence number, back to back with a zero-filled frame
		build_frame(32'hFFFF_FFFF, 16, 16'h0, 1'b0, 8'hFF, q);
		send_buffer(q, 1'b0);
		build_frame(32'h0000_0001, 16, 16'h0, 1'b0, 8'h00, q);
		send_buffer(q, 1'b1);
		// checksum mismatch
		build_frame(32'h1234_5678, 14, 16'h0, 1'b1, -1, q);
		send_buffer(q, 1'b1);
		// device errors: payload suppressed, checksum not judged
		build_frame(32'h8000_0000, 14, 16'hFFFF, 1'b1, -1, q);
		send_buffer(q, 1'b0);
		build_frame(32'h0000_00FF, 13, 16'h0001, 1'b0, -1, q);
		send_buffer(q, 1'b1);
		// length error right at the buffer end, then one that skips noise
		send_bare_header(16'd0, 0);
		send_bare_header(16'd11, 5);
		// largest length field, cut off soon after the header
		send_bare_header(16'hFFFF, 4);
		// buffer ends inside a frame at various points
		build_frame(32'hA5A5_5A5A, 20, 16'h0, 1'b0, -1, q);
		send_cut(q, 0);
		send_cut(q, 5);
		send_cut(q, 15);
		send_cut(q, 22);
		send_cut(q, q.size() - 7);
		send_cut(q, q.size() - 2);
		// a good frame right after all that
		build_frame(32'h0F0F_0F0F, 18, 16'h0, 1'b0, -1, q);
		send_buffer(q, 1'b1);
		hold_source_until_drained();
	endtask

	task automatic test_random_frames();
		int target;
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		target = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < target)
			send_random_frame();
		hold_source_until_drained();
	endtask

	// Sink holds off long enough for the block to fill and stall its input,
	// then the source stops until every result has come out.
	task automatic test_backpressure();
		byte_q_t q;
		src_idle_en       = 1'b0;
		sink_idle_en      = 1'b0;
		long_stall_cycles = LONG_STALL;
		for (int n = 0; n < 3; n++) begin
			build_frame(32'($urandom), 60, 16'h0, n == 1, -1, q);
			send_buffer(q, 1'b0);
		end
		hold_source_until_drained();
		for (int n = 0; n < 4; n++)
			send_random_frame();
		hold_source_until_drained();
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_full_rate();
		int target;
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		target = bytes_sent + STREAM_BYTES;
		while (bytes_sent < target)
			send_random_frame();
		hold_source_until_drained();
	endtask

	// ---------------------------------------------------------------
	// Clock, reset and test sequence
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n              = 1'b0;
		in_ch.valid         = 1'b0;
		in_ch.data_byte     = '0;
		in_ch.end_of_buffer = 1'b0;
		bytes_sent          = 0;
		mismatch_count      = 0;
		src_idle_en         = 1'b0;
		sink_idle_en        = 1'b0;
		long_stall_cycles   = 0;
		skip_to_eob         = 1'b0;
		start_frame();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_frames();
		test_random_frames();
		test_backpressure();
		test_full_rate();

		// let any stray result item show up before judging
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// ---------------------------------------------------------------
	// Sink side: ready driven at the falling edge
	// ---------------------------------------------------------------
	initial begin : sink_ready
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_stall_cycles > 0) begin
				// one long hold-off, counted here rather than by the source
				out_ch.ready <= 1'b0;
				repeat (long_stall_cycles - 1) @(negedge clk);
				long_stall_cycles = 0;
			end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Scoreboard: each result item against the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin : check_results
		deframe_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("%0t: extra kind %0d byte %02h seq %08h code %04h len %0d",
						$realtime, out_ch.out_kind, out_ch.out_byte, out_ch.seq_number,
						out_ch.return_code, out_ch.frame_bytes);
			end else begin
				want = pending_results.pop_front();
				if (out_ch.out_kind !== want.kind || out_ch.out_byte !== want.data ||
						out_ch.seq_number !== want.seq || out_ch.return_code !== want.code ||
						out_ch.frame_bytes !== want.flen) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX) begin
						$display("%0t: expected kind %0d byte %02h seq %08h code %04h len %0d",
							$realtime, want.kind, want.data, want.seq, want.code, want.flen);
						$display("    got kind %0d byte %02h seq %08h code %04h len %0d",
							out_ch.out_kind, out_ch.out_byte, out_ch.seq_number,
							out_ch.return_code, out_ch.frame_bytes);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: too long with no item moving on either channel
	// ---------------------------------------------------------------
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
